### src/bab_pkg.sv
// Shared types, constants and helpers for the bilinear alpha blend pixel core.
`default_nettype none
package bab_pkg;

    localparam int CHAN_W    = 8;
    localparam int NUM_CHAN  = 4;
    localparam int PIX_W     = CHAN_W * NUM_CHAN;
    localparam int ALPHA_IDX = 3;
    localparam logic [CHAN_W-1:0] ALPHA_MAX = 8'd255;
    localparam logic [CHAN_W-1:0] GALPHA_RESET = 8'd255;

    typedef struct packed {
        logic s1_en;
        logic s2_en;
    } smp_ctrl_t;

    // floor(x / 255), exact for x <= 255*255
    function automatic logic [CHAN_W-1:0] div255(input logic [2*CHAN_W-1:0] x);
        logic [2*CHAN_W:0] tmp;
        tmp = {1'b0, x} + {{(CHAN_W+1){1'b0}}, x[2*CHAN_W-1:CHAN_W]} + 17'd1;
        return tmp[2*CHAN_W-1:CHAN_W];
    endfunction

endpackage
`default_nettype wire

### src/bilinear_alpha_blend_pixel_core.sv
// Top level: bilinear texel sampling followed by alpha-over blend, fully pipelined.
`default_nettype none
// Takes one pixel request per clock while s_tready is high and returns one
// blended pixel per request, in order. The six register stages are: vertical
// lerp, horizontal lerp, sample alpha times global alpha, blend alpha, color
// products, divide by 255 and output. A stall on m_tready fills bubbles first,
// so s_tready drops only when all six stages hold data. global_alpha resets to
// 255 and must be written only while no request is in flight. Fractions use
// their low FRAC_BITS bits.
module bilinear_alpha_blend_pixel_core #(
    parameter int FRAC_BITS = 8
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          cfg_wr_en,
    input  wire  [7:0]   cfg_wr_data,     // global_alpha
    input  wire          s_tvalid,
    output logic         s_tready,
    // dest_pixel, top_left, top_right, bottom_left, bottom_right, frac_x, frac_y
    input  wire  [175:0] s_tdata,
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [31:0]  m_tdata          // blended_pixel
);

    localparam int NSTG = 6;
    localparam int CW   = bab_pkg::CHAN_W;
    localparam int PW   = bab_pkg::PIX_W;

    logic [CW-1:0]   galpha_reg;
    logic [NSTG-1:0] vld_reg, vld_next, en;
    bab_pkg::smp_ctrl_t smp_ctrl;

    logic [PW-1:0] sample_pixel;
    logic [PW-1:0] dest1_reg, dest2_reg, dest3_reg, dest4_reg;
    logic [PW-1:0] smp3_reg, smp4_reg;
    logic [2*CW-1:0] aprod_reg;
    logic [CW-1:0] a0_reg, a1_reg, a0_5_reg;
    logic [2*CW-1:0] csum_reg [bab_pkg::NUM_CHAN];
    logic [2*CW-1:0] csum_next [bab_pkg::NUM_CHAN];
    logic [PW-1:0] out_reg, out_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            galpha_reg <= bab_pkg::GALPHA_RESET;
        end else if (cfg_wr_en) begin
            galpha_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        en[NSTG-1] = !vld_reg[NSTG-1] || m_tready;
        for (int i = NSTG-2; i >= 0; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
        vld_next = vld_reg;
        if (en[0]) vld_next[0] = s_tvalid;
        for (int i = 1; i < NSTG; i++) begin
            if (en[i]) vld_next[i] = vld_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = en[0];
    assign smp_ctrl.s1_en = en[0];
    assign smp_ctrl.s2_en = en[1];

    bab_sample #(
        .FRAC_BITS (FRAC_BITS)
    ) u_sample (
        .aclk         (aclk),
        .ctrl         (smp_ctrl),
        .top_left     (s_tdata[63:32]),
        .top_right    (s_tdata[95:64]),
        .bottom_left  (s_tdata[127:96]),
        .bottom_right (s_tdata[159:128]),
        .frac_x       (s_tdata[167:160]),
        .frac_y       (s_tdata[175:168]),
        .sample_pixel (sample_pixel)
    );

    // destination travels alongside the sampler
    always_ff @(posedge aclk) begin
        if (en[0]) dest1_reg <= s_tdata[31:0];
        if (en[1]) dest2_reg <= dest1_reg;
    end

    // stage 3: sample alpha times global alpha
    always_ff @(posedge aclk) begin
        if (en[2]) begin
            dest3_reg <= dest2_reg;
            smp3_reg  <= sample_pixel;
            aprod_reg <= sample_pixel[bab_pkg::ALPHA_IDX*CW +: CW] * galpha_reg;
        end
    end

    // stage 4: blend alpha and its complement
    always_ff @(posedge aclk) begin
        if (en[3]) begin
            dest4_reg <= dest3_reg;
            smp4_reg  <= smp3_reg;
            a0_reg    <= bab_pkg::div255(aprod_reg);
            a1_reg    <= bab_pkg::ALPHA_MAX - bab_pkg::div255(aprod_reg);
        end
    end

    // stage 5: weighted sums
    always_comb begin
        for (int k = 0; k < bab_pkg::NUM_CHAN; k++) begin
            if (k == bab_pkg::ALPHA_IDX) begin
                csum_next[k] = dest4_reg[k*CW +: CW] * a1_reg;
            end else begin
                csum_next[k] = smp4_reg[k*CW +: CW] * a0_reg
                             + dest4_reg[k*CW +: CW] * a1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            a0_5_reg <= a0_reg;
            for (int k = 0; k < bab_pkg::NUM_CHAN; k++) begin
                csum_reg[k] <= csum_next[k];
            end
        end
    end

    // stage 6: divide by 255 and pack
    always_comb begin
        for (int k = 0; k < bab_pkg::NUM_CHAN; k++) begin
            if (k == bab_pkg::ALPHA_IDX) begin
                out_next[k*CW +: CW] = a0_5_reg + bab_pkg::div255(csum_reg[k]);
            end else begin
                out_next[k*CW +: CW] = bab_pkg::div255(csum_reg[k]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = vld_reg[NSTG-1];
    assign m_tdata  = out_reg;

endmodule
`default_nettype wire

### src/bab_sample.sv
// Two-stage bilinear texel sampler: vertical lerp, then horizontal lerp.
`default_nettype none
module bab_sample #(
    parameter int FRAC_BITS = 8
) (
    input  wire                          aclk,
    input  wire bab_pkg::smp_ctrl_t      ctrl,
    input  wire [bab_pkg::PIX_W-1:0]     top_left,
    input  wire [bab_pkg::PIX_W-1:0]     top_right,
    input  wire [bab_pkg::PIX_W-1:0]     bottom_left,
    input  wire [bab_pkg::PIX_W-1:0]     bottom_right,
    input  wire [7:0]                    frac_x,
    input  wire [7:0]                    frac_y,
    output logic [bab_pkg::PIX_W-1:0]    sample_pixel
);

    localparam int FW  = (FRAC_BITS < 8) ? FRAC_BITS : 8;
    localparam int WW  = FRAC_BITS + 1;
    localparam int LW  = bab_pkg::CHAN_W + FRAC_BITS + 1;
    localparam int HW  = LW + WW + 1;
    localparam logic [WW-1:0] ONE_FRAC = WW'(1) << FRAC_BITS;

    logic [WW-1:0] fx, fy, cx, cy;
    logic [WW-1:0] fx_reg, cx_reg;
    logic [LW-1:0] left_next  [bab_pkg::NUM_CHAN];
    logic [LW-1:0] right_next [bab_pkg::NUM_CHAN];
    logic [LW-1:0] left_reg   [bab_pkg::NUM_CHAN];
    logic [LW-1:0] right_reg  [bab_pkg::NUM_CHAN];
    logic [bab_pkg::PIX_W-1:0] sample_next;
    logic [bab_pkg::PIX_W-1:0] sample_reg;

    assign fx = WW'(frac_x[FW-1:0]);
    assign fy = WW'(frac_y[FW-1:0]);
    assign cx = ONE_FRAC - fx;
    assign cy = ONE_FRAC - fy;

    always_comb begin
        for (int k = 0; k < bab_pkg::NUM_CHAN; k++) begin
            left_next[k]  = LW'(top_left[k*bab_pkg::CHAN_W +: bab_pkg::CHAN_W] * cy)
                          + LW'(bottom_left[k*bab_pkg::CHAN_W +: bab_pkg::CHAN_W] * fy);
            right_next[k] = LW'(top_right[k*bab_pkg::CHAN_W +: bab_pkg::CHAN_W] * cy)
                          + LW'(bottom_right[k*bab_pkg::CHAN_W +: bab_pkg::CHAN_W] * fy);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.s1_en) begin
            fx_reg <= fx;
            cx_reg <= cx;
            for (int k = 0; k < bab_pkg::NUM_CHAN; k++) begin
                left_reg[k]  <= left_next[k];
                right_reg[k] <= right_next[k];
            end
        end
    end

    always_comb begin
        logic [HW-1:0] acc;
        sample_next = '0;
        for (int k = 0; k < bab_pkg::NUM_CHAN; k++) begin
            acc = HW'(left_reg[k] * cx_reg) + HW'(right_reg[k] * fx_reg);
            sample_next[k*bab_pkg::CHAN_W +: bab_pkg::CHAN_W] =
                acc[2*FRAC_BITS +: bab_pkg::CHAN_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.s2_en) begin
            sample_reg <= sample_next;
        end
    end

    assign sample_pixel = sample_reg;

endmodule
`default_nettype wire

### src/bab_checker.sv
// Port-level checker for the blend core, bound to the top level.
`default_nettype none
module bab_checker (
    input wire         aclk,
    input wire         aresetn,
    input wire         s_tvalid,
    input wire         s_tready,
    input wire         m_tvalid,
    input wire         m_tready,
    input wire [31:0]  m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_rst_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(s_tvalid && s_tready, 6) && $past(aresetn, 6)
        && $past(m_tready, 1) && $past(m_tready, 2) && $past(m_tready, 3)
        && $past(m_tready, 4) && $past(m_tready, 5)
        && $past(aresetn, 1) && $past(aresetn, 2) && $past(aresetn, 3)
        && $past(aresetn, 4) && $past(aresetn, 5)
        |-> m_tvalid)
        else $error("request did not reach output in six cycles");

endmodule

bind bilinear_alpha_blend_pixel_core bab_checker u_bab_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

### test/blend_pixel_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the pixel core: predicts each blended pixel and checks results in order.
module blend_pixel_checker (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          cfg_wr_en,
    input  wire  [7:0]   cfg_wr_data,
    input  wire          s_tvalid,
    input  wire          s_tready,
    input  wire  [175:0] s_tdata,
    input  wire          m_tvalid,
    input  wire          m_tready,
    input  wire  [31:0]  m_tdata,
    output int           err_cnt,
    output int           pending_cnt
);

    localparam int FRAC_W    = 8;
    localparam int UNIT      = 1 << FRAC_W;
    localparam int CHAN_W    = bab_pkg::CHAN_W;
    localparam int NUM_CHAN  = bab_pkg::NUM_CHAN;
    localparam int ALPHA_IDX = bab_pkg::ALPHA_IDX;

    // request layout, low bits last
    typedef struct packed {
        logic [7:0]  frac_y;
        logic [7:0]  frac_x;
        logic [31:0] bot_right;
        logic [31:0] bot_left;
        logic [31:0] top_right;
        logic [31:0] top_left;
        logic [31:0] dest;
    } pix_req_t;

    logic [7:0]  galpha;
    logic [31:0] blended_q [$];
    logic [31:0] want;

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        err_cnt = err_cnt + 1;
    endtask

    function automatic int unsigned texel_sample(input pix_req_t r, input int k);
        int unsigned tl, tr, bl, br, fx, fy, cx, cy;
        tl = 32'(r.top_left[k*CHAN_W +: CHAN_W]);
        tr = 32'(r.top_right[k*CHAN_W +: CHAN_W]);
        bl = 32'(r.bot_left[k*CHAN_W +: CHAN_W]);
        br = 32'(r.bot_right[k*CHAN_W +: CHAN_W]);
        fx = 32'(r.frac_x) & (UNIT - 1);
        fy = 32'(r.frac_y) & (UNIT - 1);
        cx = UNIT - fx;
        cy = UNIT - fy;
        if (fx != 0 && fy != 0)
            return ((tl * cy + bl * fy) * cx + (tr * cy + br * fy) * fx) >> (2 * FRAC_W);
        if (fx != 0)
            return (tl * cx + tr * fx) >> FRAC_W;
        if (fy != 0)
            return (tl * cy + bl * fy) >> FRAC_W;
        return tl;
    endfunction

    function automatic logic [31:0] blend_pixel(input pix_req_t r, input logic [7:0] ga);
        int unsigned smp [NUM_CHAN];
        int unsigned amax, a_src, a_dst, d;
        logic [31:0] px;
        amax = int'(bab_pkg::ALPHA_MAX);
        for (int k = 0; k < NUM_CHAN; k++)
            smp[k] = texel_sample(r, k) & 32'hFF;
        a_src = smp[ALPHA_IDX] * int'(ga) / amax;
        a_dst = amax - a_src;
        for (int k = 0; k < ALPHA_IDX; k++) begin
            d = 32'(r.dest[k*CHAN_W +: CHAN_W]);
            px[k*CHAN_W +: CHAN_W] = 8'((smp[k] * a_src + d * a_dst) / amax);
        end
        d = 32'(r.dest[ALPHA_IDX*CHAN_W +: CHAN_W]);
        px[ALPHA_IDX*CHAN_W +: CHAN_W] = 8'(a_src + d * a_dst / amax);
        return px;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            galpha <= bab_pkg::GALPHA_RESET;
            blended_q.delete();
            pending_cnt <= 0;
            err_cnt = 0;
        end else begin
            if (cfg_wr_en)
                galpha <= cfg_wr_data;
            if (m_tvalid && m_tready) begin
                if (blended_q.size() == 0) begin
                    report_mismatch($sformatf("pixel %08h with no request pending", m_tdata));
                end else begin
                    want = blended_q.pop_front();
                    if (m_tdata !== want)
                        report_mismatch($sformatf("blended_pixel %08h, want %08h",
                                                  m_tdata, want));
                end
            end
            if (s_tvalid && s_tready)
                blended_q.push_back(blend_pixel(pix_req_t'(s_tdata), galpha));
            pending_cnt <= blended_q.size();
        end
    end

endmodule

### test/bilinear_alpha_blend_pixel_core_tb.sv
`timescale 1ns / 100ps
// Testbench top: drives pixel requests and alpha settings, gives the verdict.
module bilinear_alpha_blend_pixel_core_tb;

    logic         aclk        = 1'b0;
    logic         aresetn     = 1'b0;
    logic         cfg_wr_en   = 1'b0;
    logic [7:0]   cfg_wr_data = 8'd0;
    logic         s_tvalid    = 1'b0;
    logic [175:0] s_tdata     = '0;
    logic         m_tready    = 1'b0;
    wire          s_tready;
    wire          m_tvalid;
    wire  [31:0]  m_tdata;

    int err_cnt;
    int pending_cnt;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;

    logic [7:0] alpha_set [8] = '{8'd0, 8'd255, 8'd1, 8'd128, 8'd0, 8'd254, 8'd0, 8'd77};

    always #4 aclk = ~aclk;

    always @(negedge aclk)
        m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);

    bilinear_alpha_blend_pixel_core #(
        .FRAC_BITS(8)
    ) u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    blend_pixel_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .err_cnt     (err_cnt),
        .pending_cnt (pending_cnt)
    );

    task automatic send_pixel(input logic [31:0] dest, tl, tr, bl, br,
                              input logic [7:0] fx, fy);
        @(negedge aclk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {fy, fx, br, bl, tr, tl, dest};
        do @(posedge aclk); while (!s_tready);
    endtask

    // hold off requests until every blended pixel is back
    task automatic drain_pixels();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_cnt != 0)
            @(posedge aclk);
    endtask

    task automatic write_global_alpha(input logic [7:0] val);
        drain_pixels();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [31:0] rand_texel();
        logic [31:0] t;
        t = $urandom;
        case ($urandom_range(0, 7))
            0: t[31:24] = 8'hFF;
            1: t[31:24] = 8'h00;
            default: ;
        endcase
        return t;
    endfunction

    function automatic logic [7:0] rand_frac();
        case ($urandom_range(0, 5))
            0: return 8'd1;
            1: return 8'd255;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    task automatic send_random_pixel();
        logic [7:0] fx, fy;
        fx = 8'd0;
        fy = 8'd0;
        case ($urandom_range(0, 3))
            1: fx = rand_frac();
            2: fy = rand_frac();
            3: begin
                fx = rand_frac();
                fy = rand_frac();
            end
            default: ;
        endcase
        send_pixel(rand_texel(), rand_texel(), rand_texel(), rand_texel(), rand_texel(), fx, fy);
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // blit, one-axis and bilinear corners at reset alpha
        send_pixel(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 8'd0, 8'd0);
        send_pixel('1, '1, '1, '1, '1, 8'd0, 8'd0);
        send_pixel(32'h7F102030, 32'h80FF4020, 32'h12345678, 32'h9ABCDEF0, 32'h0, 8'd0, 8'd0);
        send_pixel(32'h0, 32'h0, '1, 32'h5A5A5A5A, 32'hA5A5A5A5, 8'd1, 8'd0);
        send_pixel(32'h0, 32'h0, '1, 32'h5A5A5A5A, 32'hA5A5A5A5, 8'd255, 8'd0);
        send_pixel('1, 32'h0, 32'hC3C3C3C3, '1, 32'h3C3C3C3C, 8'd0, 8'd1);
        send_pixel('1, 32'h0, 32'hC3C3C3C3, '1, 32'h3C3C3C3C, 8'd0, 8'd255);
        send_pixel(32'h40404040, 32'h0, '1, '1, '1, 8'd1, 8'd1);
        send_pixel(32'h40404040, '1, '1, '1, 32'h0, 8'd255, 8'd255);
        send_pixel(32'h80808080, 32'hFF0000FF, 32'hFF00FF00, 32'hFFFF0000, 32'hFFFFFFFF,
                   8'd128, 8'd128);
        send_pixel('1, 32'h00FFFFFF, 32'h00FFFFFF, 32'h00FFFFFF, 32'h00FFFFFF, 8'd0, 8'd0);
        send_pixel(32'h0, 32'hFF804020, 32'h0, 32'h0, 32'h0, 8'd0, 8'd0);
        send_pixel(32'h11223344, 32'h80C0E0F0, 32'h40302010, '1, '1, 8'd77, 8'd0);
        send_pixel(32'hCAFEBABE, 32'h01020304, 32'hFEFDFCFB, 32'h7F7F7F7F, 32'h80808080,
                   8'd200, 8'd33);

        for (int ph = 0; ph < 8; ph++) begin
            write_global_alpha((ph == 4 || ph == 6) ? 8'($urandom_range(2, 253)) : alpha_set[ph]);
            case (ph % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 51; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 51; end
                default: begin tx_idle_pct = 33; rx_stall_pct = 33; end
            endcase
            for (int i = 0; i < 225; i++)
                send_random_pixel();
        end

        drain_pixels();
        rx_stall_pct = 0;
        repeat (20) @(posedge aclk);
        if (err_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout");
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
src/bab_pkg.sv
src/bab_sample.sv
src/bilinear_alpha_blend_pixel_core.sv
src/bab_checker.sv
test/blend_pixel_checker.sv
test/bilinear_alpha_blend_pixel_core_tb.sv
